// File: sv/tasgd_pkg.sv
`timescale 1ns / 1ps

package tasgd_pkg;

    localparam int SAMPLE_BITS        = 16;
    localparam int COUNT_BITS_DEFAULT = 8;
    localparam int AXES               = 3;

    localparam int THRESH_BITS = 16;
    localparam int RUN_LEN_BITS = 8;
    localparam int CFG_INDEX_BITS = 2;

    // wide enough for |a - b| of two samples and for a 16-bit threshold
    localparam int MAG_BITS = (SAMPLE_BITS + 1 > THRESH_BITS) ? SAMPLE_BITS + 1 : THRESH_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANGE_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_RUN_LENGTH   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SWING_THRESHOLD  = 2'd2;

    localparam logic [THRESH_BITS-1:0]  CHANGE_THRESHOLD_RST = 16'd64;
    localparam logic [RUN_LEN_BITS-1:0] MIN_RUN_LENGTH_RST   = 8'd8;
    localparam logic [THRESH_BITS-1:0]  SWING_THRESHOLD_RST  = 16'd2048;

    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] accel_x;
        logic signed [SAMPLE_BITS-1:0] accel_y;
        logic signed [SAMPLE_BITS-1:0] accel_z;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                    x_direction;
        logic signed [SAMPLE_BITS-1:0] x_extreme;
        logic [1:0]                    y_direction;
        logic signed [SAMPLE_BITS-1:0] y_extreme;
        logic [1:0]                    z_direction;
        logic signed [SAMPLE_BITS-1:0] z_extreme;
    } t_out_item;

    typedef struct packed {
        logic [THRESH_BITS-1:0]  change_threshold;
        logic [RUN_LEN_BITS-1:0] min_run_length;
        logic [THRESH_BITS-1:0]  swing_threshold;
    } t_cfg;

    typedef struct packed {
        logic moved;
        logic report;
    } t_axis_flags;

endpackage

// File: sv/tasgd_axis.sv
`timescale 1ns / 1ps

module tasgd_axis #(
    parameter int COUNT_BITS = tasgd_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_go,
    input  logic                                     i_first,
    input  logic                                     i_still,
    input  logic signed [tasgd_pkg::SAMPLE_BITS-1:0] i_sample,
    input  tasgd_pkg::t_cfg                          i_cfg,
    output tasgd_pkg::t_axis_flags                   o_flags,
    output logic [1:0]                               o_dir,
    output logic signed [tasgd_pkg::SAMPLE_BITS-1:0] o_extreme
);
    import tasgd_pkg::*;

    localparam int LEN_BITS = (COUNT_BITS > RUN_LEN_BITS) ? COUNT_BITS : RUN_LEN_BITS;

    logic signed [SAMPLE_BITS-1:0] r_prev, n_prev;
    logic signed [SAMPLE_BITS-1:0] r_min, n_min;
    logic signed [SAMPLE_BITS-1:0] r_max, n_max;
    logic [COUNT_BITS-1:0]         r_cnt, n_cnt;
    logic                          r_later, n_later;

    logic signed [SAMPLE_BITS-1:0] prev_eff;
    logic signed [SAMPLE_BITS:0]   diff;
    logic [SAMPLE_BITS:0]          mag;
    logic [SAMPLE_BITS:0]          spread;
    logic                          moved;
    logic                          judge;
    logic                          swing;

    always_comb begin
        // first sample compares against itself, so it never counts as motion
        prev_eff = i_first ? i_sample : r_prev;
        diff     = {i_sample[SAMPLE_BITS-1], i_sample} - {prev_eff[SAMPLE_BITS-1], prev_eff};
        mag      = diff[SAMPLE_BITS] ? $unsigned(-diff) : $unsigned(diff);
        moved    = MAG_BITS'(mag) > MAG_BITS'(i_cfg.change_threshold);

        // max >= min always holds, so the difference is non-negative
        spread = $unsigned({r_max[SAMPLE_BITS-1], r_max} - {r_min[SAMPLE_BITS-1], r_min});
        swing  = MAG_BITS'(spread) > MAG_BITS'(i_cfg.swing_threshold);
        judge  = i_still && (LEN_BITS'(r_cnt) >= LEN_BITS'(i_cfg.min_run_length));

        o_flags.moved  = moved;
        o_flags.report = judge && swing;
        if (judge && swing) begin
            o_dir     = r_later ? DIR_RIGHT : DIR_LEFT;
            o_extreme = r_later ? r_max : r_min;
        end else begin
            o_dir     = DIR_NONE;
            o_extreme = '0;
        end
    end

    always_comb begin
        n_prev  = i_sample;
        n_min   = r_min;
        n_max   = r_max;
        n_cnt   = r_cnt;
        n_later = r_later;
        if (moved) begin
            priority if (r_cnt == '0) begin
                n_min   = i_sample;
                n_max   = i_sample;
                n_later = 1'b0;
            end else if (i_sample < r_min) begin
                n_min   = i_sample;
                n_later = 1'b0;
            end else if (i_sample > r_max) begin
                n_max   = i_sample;
                n_later = 1'b1;
            end else begin
                // within the current bounds or tied: extremes stay put
                n_later = r_later;
            end
            if (r_cnt != '1) begin
                n_cnt = r_cnt + 1'b1;
            end
        end else if (judge) begin
            n_min   = '0;
            n_max   = '0;
            n_cnt   = '0;
            n_later = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_min   <= '0;
            r_max   <= '0;
            r_cnt   <= '0;
            r_later <= 1'b0;
        end else if (i_go) begin
            r_prev  <= n_prev;
            r_min   <= n_min;
            r_max   <= n_max;
            r_cnt   <= n_cnt;
            r_later <= n_later;
        end
    end

endmodule

// File: sv/three_axis_swing_gesture_detector_top.sv
`timescale 1ns / 1ps
// Pipeline: a transferred sample passes through the input register, then the result register.
// Throughput: one sample per cycle unless i_out_stall holds a result; the per-axis run update
// is a direct loop through its own state registers.
// A result held by i_out_stall holds the input register and so stalls the input.
// Reset: i_rst_n synchronous, active low; clears the runs, the previous samples,
// the pipeline valids and restores the register defaults.

module three_axis_swing_gesture_detector_top #(
    parameter int COUNT_BITS = tasgd_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  tasgd_pkg::t_in_item                   i_in_item,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output tasgd_pkg::t_out_item                  o_out_item,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tasgd_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [tasgd_pkg::THRESH_BITS-1:0]     i_cfg_data
);
    import tasgd_pkg::*;

    t_cfg      r_cfg;
    logic      r_first;
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic                          go;
    logic                          still;
    logic                          any_report;
    logic signed [SAMPLE_BITS-1:0] sample   [AXES];
    t_axis_flags                   flags    [AXES];
    logic [1:0]                    dir      [AXES];
    logic signed [SAMPLE_BITS-1:0] extreme  [AXES];
    t_out_item                     result;

    // register writes wait until the input register has drained
    assign o_cfg_ready = !r_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.change_threshold <= CHANGE_THRESHOLD_RST;
            r_cfg.min_run_length   <= MIN_RUN_LENGTH_RST;
            r_cfg.swing_threshold  <= SWING_THRESHOLD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CHANGE_THRESHOLD: r_cfg.change_threshold <= i_cfg_data;
                CFG_MIN_RUN_LENGTH:   r_cfg.min_run_length   <= i_cfg_data[RUN_LEN_BITS-1:0];
                CFG_SWING_THRESHOLD:  r_cfg.swing_threshold  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the sample in the input register is processed once the result slot can take it
    assign go         = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (go) begin
            r_first <= 1'b0;
        end
    end

    assign sample[0] = r_in.accel_x;
    assign sample[1] = r_in.accel_y;
    assign sample[2] = r_in.accel_z;

    // a sample is still only when no axis moved
    assign still      = !(flags[0].moved || flags[1].moved || flags[2].moved);
    assign any_report = flags[0].report || flags[1].report || flags[2].report;

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        tasgd_axis #(
            .COUNT_BITS (COUNT_BITS)
        ) u_axis (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_go      (go),
            .i_first   (r_first),
            .i_still   (still),
            .i_sample  (sample[a]),
            .i_cfg     (r_cfg),
            .o_flags   (flags[a]),
            .o_dir     (dir[a]),
            .o_extreme (extreme[a])
        );
    end

    always_comb begin
        result.x_direction = dir[0];
        result.x_extreme   = extreme[0];
        result.y_direction = dir[1];
        result.y_extreme   = extreme[1];
        result.z_direction = dir[2];
        result.z_extreme   = extreme[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go) begin
            r_out_valid <= any_report;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTH
    a_result_has_swing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.x_direction != DIR_NONE ||
                         o_out_item.y_direction != DIR_NONE ||
                         o_out_item.z_direction != DIR_NONE))
        else $error("result transfer without any swing");

    a_quiet_axis_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.x_direction == DIR_NONE) |-> o_out_item.x_extreme == '0)
        else $error("x extreme nonzero without a swing");

    a_report_only_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        any_report |-> still)
        else $error("swing judged on a moving sample");

    a_first_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |=> !r_first)
        else $error("first-sample flag survived a processed sample");
`endif

endmodule

// File: test/three_axis_swing_gesture_detector_top_test.sv
`timescale 1ns / 1ps

module three_axis_swing_gesture_detector_top_test;

    import tasgd_pkg::*;

    localparam int SMP_MAX     = 32767;
    localparam int SMP_MIN     = -32768;
    localparam int COUNT_LIMIT = (1 << COUNT_BITS_DEFAULT) - 1;
    localparam int IN_BITS     = $bits(t_in_item);
    // two register stages plus margin
    localparam int PIPE_CYCLES = 4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 2'd3;

    logic                      i_clk;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_stall;
    t_in_item                  i_in_item   = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    t_out_item                 o_out_item;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [THRESH_BITS-1:0]    i_cfg_data  = '0;

    three_axis_swing_gesture_detector_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor copy of registers and per-axis run state
    int cfg_change_thr = CHANGE_THRESHOLD_RST;
    int cfg_min_len    = MIN_RUN_LENGTH_RST;
    int cfg_swing_thr  = SWING_THRESHOLD_RST;
    bit first_pending  = 1'b1;
    int prev_smp [AXES] = '{default: 0};
    int run_lo   [AXES] = '{default: 0};
    int run_hi   [AXES] = '{default: 0};
    int run_len  [AXES] = '{default: 0};
    bit hi_later [AXES] = '{default: 1'b0};

    t_out_item pending_gestures [$];
    int        last_smp [AXES] = '{default: 0};
    bit        idle_on      = 1'b1;
    int        out_wait     = 0;
    int        err_count    = 0;
    int        sample_count = 0;
    int        report_count = 0;
    int        cfg_writes   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("three_axis_swing_gesture_detector_top_test NOT OK");
        $finish;
    end

    function automatic bit predict_gesture(input t_in_item item,
                                           output t_out_item res);
        int               smp [AXES];
        logic [1:0]       dir [AXES];
        logic [SAMPLE_BITS-1:0] ext [AXES];
        int               delta;
        bit               moved;
        bit               hit;
        smp[0] = $signed(item.accel_x);
        smp[1] = $signed(item.accel_y);
        smp[2] = $signed(item.accel_z);
        moved = 1'b0;
        hit   = 1'b0;
        if (first_pending) begin
            for (int a = 0; a < AXES; a++) prev_smp[a] = smp[a];
            first_pending = 1'b0;
        end
        for (int a = 0; a < AXES; a++) begin
            dir[a] = DIR_NONE;
            ext[a] = '0;
            delta = smp[a] - prev_smp[a];
            if (delta < 0) delta = -delta;
            if (delta > cfg_change_thr) begin
                moved = 1'b1;
                if (run_len[a] == 0) begin
                    run_lo[a]   = smp[a];
                    run_hi[a]   = smp[a];
                    hi_later[a] = 1'b0;
                end else if (smp[a] < run_lo[a]) begin
                    run_lo[a]   = smp[a];
                    hi_later[a] = 1'b0;
                end else if (smp[a] > run_hi[a]) begin
                    run_hi[a]   = smp[a];
                    hi_later[a] = 1'b1;
                end
                if (run_len[a] < COUNT_LIMIT) run_len[a]++;
            end
            prev_smp[a] = smp[a];
        end
        if (!moved) begin
            for (int a = 0; a < AXES; a++) begin
                if (run_len[a] >= cfg_min_len) begin
                    if (run_hi[a] - run_lo[a] > cfg_swing_thr) begin
                        dir[a] = hi_later[a] ? DIR_RIGHT : DIR_LEFT;
                        ext[a] = hi_later[a] ? 16'(run_hi[a]) : 16'(run_lo[a]);
                        hit    = 1'b1;
                    end
                    run_lo[a]   = 0;
                    run_hi[a]   = 0;
                    run_len[a]  = 0;
                    hi_later[a] = 1'b0;
                end
            end
        end
        res.x_direction = dir[0];
        res.x_extreme   = ext[0];
        res.y_direction = dir[1];
        res.y_extreme   = ext[1];
        res.z_direction = dir[2];
        res.z_extreme   = ext[2];
        return hit;
    endfunction

    task automatic check_gesture(input t_out_item got);
        t_out_item want;
        bit        bad;
        report_count++;
        if (pending_gestures.size() == 0) begin
            err_count++;
            if (err_count <= 10)
                $display("ERROR: gesture with none pending: x=%0d/%0d y=%0d/%0d z=%0d/%0d",
                         got.x_direction, got.x_extreme, got.y_direction, got.y_extreme,
                         got.z_direction, got.z_extreme);
            return;
        end
        want = pending_gestures.pop_front();
        bad = (got.x_direction !== want.x_direction) || (got.x_extreme !== want.x_extreme) ||
              (got.y_direction !== want.y_direction) || (got.y_extreme !== want.y_extreme) ||
              (got.z_direction !== want.z_direction) || (got.z_extreme !== want.z_extreme);
        if (bad) begin
            err_count++;
            if (err_count <= 10)
                $display({"ERROR: gesture exp x=%0d/%0d y=%0d/%0d z=%0d/%0d,",
                          " got x=%0d/%0d y=%0d/%0d z=%0d/%0d"},
                         want.x_direction, want.x_extreme, want.y_direction, want.y_extreme,
                         want.z_direction, want.z_extreme, got.x_direction, got.x_extreme,
                         got.y_direction, got.y_extreme, got.z_direction, got.z_extreme);
        end
    endtask

    // result side: check each transfer, then, while idle_on is set, hold stall at random
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            check_gesture(o_out_item);
            out_wait = idle_on ? $urandom_range(0, 9) : 0;
        end else if (out_wait > 0) begin
            out_wait--;
        end
        i_out_stall <= (out_wait > 0);
    end

    task automatic send_sample(input t_in_item item);
        int        gap;
        t_out_item res;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        do @(posedge i_clk); while (o_in_stall);
        if (predict_gesture(item, res)) pending_gestures = {pending_gestures, res};
        last_smp[0] = $signed(item.accel_x);
        last_smp[1] = $signed(item.accel_y);
        last_smp[2] = $signed(item.accel_z);
        sample_count++;
    endtask

    task automatic send_xyz(input int x, input int y, input int z);
        t_in_item item;
        item.accel_x = 16'(x);
        item.accel_y = 16'(y);
        item.accel_z = 16'(z);
        send_sample(item);
    endtask

    // wait out every pending gesture plus the pipeline, input side idle
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_gestures.size() > 0) @(posedge i_clk);
        repeat (PIPE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [THRESH_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_CHANGE_THRESHOLD: cfg_change_thr = data;
            CFG_MIN_RUN_LENGTH:   cfg_min_len    = data[RUN_LEN_BITS-1:0];
            CFG_SWING_THRESHOLD:  cfg_swing_thr  = data;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_config(input logic [THRESH_BITS-1:0] change_thr,
                              input logic [THRESH_BITS-1:0] run_len_data,
                              input logic [THRESH_BITS-1:0] swing_thr);
        write_reg(CFG_CHANGE_THRESHOLD, change_thr);
        write_reg(CFG_MIN_RUN_LENGTH, run_len_data);
        write_reg(CFG_SWING_THRESHOLD, swing_thr);
        i_cfg_valid <= 1'b0;
    endtask

    // next sample as a random walk: moving axes step past the change threshold
    function automatic t_in_item step_item(input bit move);
        int       nxt [AXES];
        int       mag;
        t_in_item item;
        for (int a = 0; a < AXES; a++) begin
            if (move && $urandom_range(0, 9) < 8)
                mag = cfg_change_thr + 1 + $urandom_range(0, 4000);
            else
                mag = $urandom_range(0, cfg_change_thr);
            nxt[a] = $urandom_range(0, 1) ? last_smp[a] + mag : last_smp[a] - mag;
            if (nxt[a] > SMP_MAX) nxt[a] = last_smp[a] - mag;
            if (nxt[a] < SMP_MIN) nxt[a] = last_smp[a] + mag;
            if (nxt[a] > SMP_MAX) nxt[a] = SMP_MAX;
        end
        item.accel_x = 16'(nxt[0]);
        item.accel_y = 16'(nxt[1]);
        item.accel_z = 16'(nxt[2]);
        return item;
    endfunction

    task automatic send_gesture();
        int n_moves;
        n_moves = $urandom_range(0, cfg_min_len + 3);
        if (n_moves > 40) n_moves = $urandom_range(0, 40);
        repeat (n_moves) send_sample(step_item(1'b1));
        repeat ($urandom_range(1, 2)) send_sample(step_item(1'b0));
    endtask

    // mostly well-formed gestures, some raw noise samples
    task automatic send_stream(input int n);
        int target;
        target = sample_count + n;
        while (sample_count < target) begin
            if ($urandom_range(0, 99) < 15)
                send_sample(t_in_item'(IN_BITS'({$urandom, $urandom})));
            else
                send_gesture();
        end
    endtask

    task automatic test_directed_swings();
        // first sample seeds the previous value, no motion
        send_xyz(32767, -32768, 0);
        send_xyz(32767, -32768, 0);
        // x swings rail to rail with ties, y drifts too little, z short run
        for (int a = 0; a < 8; a++)
            send_xyz((a % 2) ? 32767 : -32768, -32668 + 100 * a,
                     (a == 1) ? 0 : 1000);
        send_xyz(32767, -31968, 1000);
        // z run continues past the still sample, min comes last
        for (int a = 0; a < 5; a++)
            send_xyz(32767, -31968, (a % 2) ? 1000 : -3000);
        send_xyz(32767, -31968, -3000);
        // change exactly at threshold is not motion
        send_xyz(32703, -31904, -3000);
        // spread exactly at swing threshold: judged, no report
        for (int a = 0; a < 8; a++)
            send_xyz((a % 2) ? 2048 : 0, -31904, -3000);
        send_xyz(2048, -31904, -3000);
    endtask

    task automatic test_config_extremes();
        settle();
        set_config(16'd0, {8'($urandom), 8'd1}, 16'd0);
        send_stream(80);
        settle();
        // run length zero: empty runs judged on every still sample
        set_config(16'd300, {8'($urandom), 8'd0}, 16'd3000);
        send_stream(60);
        settle();
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (int a = 0; a < 4; a++) begin
            send_xyz(SMP_MIN, SMP_MIN, SMP_MIN);
            send_xyz(SMP_MAX, SMP_MAX, SMP_MAX);
        end
        send_stream(30);
    endtask

    task automatic test_count_saturation();
        settle();
        set_config(16'd64, {8'($urandom), 8'd255}, 16'd2048);
        for (int a = 0; a < 300; a++)
            send_xyz((a % 2) ? 10000 : -10000, 5, 5);
        send_xyz(10000, 5, 5);
    endtask

    task automatic test_unused_index();
        settle();
        set_config(16'd100, {8'($urandom), 8'd4}, 16'd1000);
        write_reg(CFG_UNUSED_INDEX, 16'($urandom));
        i_cfg_valid <= 1'b0;
        send_stream(60);
    endtask

    task automatic test_random_gestures();
        for (int ph = 0; ph < 8; ph++) begin
            settle();
            set_config(16'($urandom_range(0, 2000)),
                       {8'($urandom), 8'($urandom_range(0, 12))},
                       16'($urandom_range(0, 20000)));
            idle_on = (ph != 3);
            send_stream(40);
            settle();
            send_stream(40);
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_swings();
        test_config_extremes();
        test_count_saturation();
        test_unused_index();
        test_random_gestures();
        settle();
        $display("Sent %0d samples, checked %0d gesture reports, %0d register writes.",
                 sample_count, report_count, cfg_writes);
        $display("Covered rail values, threshold edges, zero and saturated run lengths; %0d failures.",
                 err_count);
        if (err_count == 0)
            $display("three_axis_swing_gesture_detector_top_test OK");
        else
            $display("three_axis_swing_gesture_detector_top_test NOT OK");
        $finish;
    end

endmodule
